// ===== hw/rtl/hold_to_approve_button_controller_top_macros.svh =====
// assertion macros used by the hold-to-approve controller top level
`ifndef HOLD_TO_APPROVE_BUTTON_CONTROLLER_TOP_MACROS_SVH
`define HOLD_TO_APPROVE_BUTTON_CONTROLLER_TOP_MACROS_SVH

// concurrent property checked at every clock edge outside reset
`define HTAB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the cause
`define HTAB_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ===== hw/rtl/htab_pkg.sv =====
// types and constants of the hold-to-approve button controller
package htab_pkg;

   localparam logic [1:0] OP_POLL   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_ARMED     = 3'd1;
   localparam logic [2:0] EV_CANCELLED = 3'd2;
   localparam logic [2:0] EV_APPROVED  = 3'd3;
   localparam logic [2:0] EV_EXPIRED   = 3'd4;

   localparam logic [2:0] REG_DEBOUNCE_TIME  = 3'd0;
   localparam logic [2:0] REG_HOLD_TIME      = 3'd1;
   localparam logic [2:0] REG_DEFAULT_EXPIRY = 3'd2;
   localparam logic [2:0] REG_EXPIRY_MARGIN  = 3'd3;
   localparam logic [2:0] REG_BLINK_FAST     = 3'd4;
   localparam logic [2:0] REG_BLINK_SLOW     = 3'd5;

   localparam logic [15:0] DEBOUNCE_TIME_RESET  = 16'd35;
   localparam logic [15:0] HOLD_TIME_RESET      = 16'd1000;
   localparam logic [31:0] DEFAULT_EXPIRY_RESET = 32'd30000;
   localparam logic [15:0] EXPIRY_MARGIN_RESET  = 16'd500;
   localparam logic [15:0] BLINK_FAST_RESET     = 16'd90;
   localparam logic [15:0] BLINK_SLOW_RESET     = 16'd350;

   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] hold_time;
      logic [31:0] default_expiry;
      logic [15:0] expiry_margin;
      logic [15:0] blink_fast;
      logic [15:0] blink_slow;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_ms;
      logic        raw_button;
      logic [31:0] request_tag;
      logic        tag_given;
      logic        expiry_given;
      logic [31:0] expiry_request;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] event_tag;
      logic [31:0] held_time;
      logic [31:0] armed_expiry;
      logic        led_on;
      logic        pending_now;
   } rsp_type;

endpackage

// ===== hw/rtl/hold_to_approve_button_controller_top.sv =====
// Hold-to-approve button controller. Every request beat (poll, arm or cancel)
// yields exactly one response beat. A beat is captured in an input register;
// once the output register is free, the controller state is updated in one
// pass and the response lands in the output register on the same edge, so a
// new beat is taken every cycle as long as the response side does not stall.
// The rate is set by the one-pass state update in htab_core: each beat sees the
// state left by the one before it. Configuration writes take effect on the next
// edge and should be made only while no beat is in flight.
`include "hold_to_approve_button_controller_top_macros.svh"

module hold_to_approve_button_controller_top
   import htab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic        req_raw_button,
   input  logic [31:0] req_request_tag,
   input  logic        req_tag_given,
   input  logic        req_expiry_given,
   input  logic [31:0] req_expiry_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [31:0] rsp_event_tag,
   output logic [31:0] rsp_held_time,
   output logic [31:0] rsp_armed_expiry,
   output logic        rsp_led_on,
   output logic        rsp_pending_now,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg;
   req_type req_ff, req_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff;
   rsp_type core_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    fire;
   logic    take;

   htab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   htab_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .cfg   (cfg),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   // output register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      req_in.opcode         = req_opcode;
      req_in.now_ms         = req_now_ms;
      req_in.raw_button     = req_raw_button;
      req_in.request_tag    = req_request_tag;
      req_in.tag_given      = req_tag_given;
      req_in.expiry_given   = req_expiry_given;
      req_in.expiry_request = req_expiry_request;
      req_valid_in          = take || (req_valid_ff && !fire);
      rsp_valid_in          = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_event_tag    = rsp_ff.event_tag;
   assign rsp_held_time    = rsp_ff.held_time;
   assign rsp_armed_expiry = rsp_ff.armed_expiry;
   assign rsp_led_on       = rsp_ff.led_on;
   assign rsp_pending_now  = rsp_ff.pending_now;

   `HTAB_ASSERT(a_stall_only_when_full, req_stall |-> (req_valid_ff && rsp_valid_ff), "request stalled with room ahead")
   `HTAB_ASSERT_NEXT(a_fire_fills_output, fire, rsp_valid_ff, "processed beat did not reach output")
   `HTAB_ASSERT(a_led_needs_armed, (rsp_valid_ff && rsp_led_on) |-> rsp_pending_now, "led lit with nothing armed")
   `HTAB_ASSERT(a_armed_event_pending, (rsp_valid_ff && rsp_event_res == EV_ARMED) |-> rsp_pending_now, "armed event without pending request")
   `HTAB_ASSERT(a_held_only_on_approve, (rsp_valid_ff && rsp_event_res != EV_APPROVED) |-> (rsp_held_time == 32'd0), "held time outside approval")

endmodule

// ===== hw/rtl/htab_csr.sv =====
// configuration registers of the hold-to-approve controller
module htab_csr
   import htab_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:  cfg_in.debounce_time  = csr_data[15:0];
            REG_HOLD_TIME:      cfg_in.hold_time      = csr_data[15:0];
            REG_DEFAULT_EXPIRY: cfg_in.default_expiry = csr_data;
            REG_EXPIRY_MARGIN:  cfg_in.expiry_margin  = csr_data[15:0];
            REG_BLINK_FAST:     cfg_in.blink_fast     = csr_data[15:0];
            REG_BLINK_SLOW:     cfg_in.blink_slow     = csr_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time  <= DEBOUNCE_TIME_RESET;
         cfg_ff.hold_time      <= HOLD_TIME_RESET;
         cfg_ff.default_expiry <= DEFAULT_EXPIRY_RESET;
         cfg_ff.expiry_margin  <= EXPIRY_MARGIN_RESET;
         cfg_ff.blink_fast     <= BLINK_FAST_RESET;
         cfg_ff.blink_slow     <= BLINK_SLOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/htab_core.sv =====
// controller state and the single-pass update for one beat
module htab_core
   import htab_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   logic        last_raw_ff, last_raw_in;
   logic        stable_level_ff, stable_level_in;
   logic [31:0] bounce_stamp_ff, bounce_stamp_in;
   logic [31:0] press_stamp_ff, press_stamp_in;
   logic        sent_this_press_ff, sent_this_press_in;
   logic        need_release_ff, need_release_in;
   logic [31:0] blink_stamp_ff, blink_stamp_in;
   logic        led_level_ff, led_level_in;
   logic        armed_ff, armed_in;
   logic [31:0] arm_stamp_ff, arm_stamp_in;
   logic [31:0] expiry_value_ff, expiry_value_in;
   logic [31:0] armed_tag_ff, armed_tag_in;

   logic [16:0] min_expiry;
   logic [31:0] chosen_expiry;
   logic [31:0] clamped_expiry;
   logic [31:0] bounce_age;
   logic [31:0] hold_age;
   logic [31:0] blink_age;
   logic [15:0] interval;
   logic        approved;

   assign min_expiry    = {1'b0, cfg.hold_time} + {1'b0, cfg.expiry_margin};
   assign chosen_expiry = req.expiry_given ? req.expiry_request : cfg.default_expiry;
   assign clamped_expiry = (chosen_expiry < {15'd0, min_expiry})
                         ? {15'd0, min_expiry} : chosen_expiry;

   always_comb begin
      last_raw_in        = last_raw_ff;
      stable_level_in    = stable_level_ff;
      bounce_stamp_in    = bounce_stamp_ff;
      press_stamp_in     = press_stamp_ff;
      sent_this_press_in = sent_this_press_ff;
      need_release_in    = need_release_ff;
      blink_stamp_in     = blink_stamp_ff;
      led_level_in       = led_level_ff;
      armed_in           = armed_ff;
      arm_stamp_in       = arm_stamp_ff;
      expiry_value_in    = expiry_value_ff;
      armed_tag_in       = armed_tag_ff;
      approved           = 1'b0;
      bounce_age         = 32'd0;
      hold_age           = 32'd0;
      blink_age          = 32'd0;
      interval           = cfg.blink_slow;
      rsp                = '0;

      case (req.opcode)
         OP_ARM: begin
            expiry_value_in    = clamped_expiry;
            armed_tag_in       = req.request_tag;
            arm_stamp_in       = req.now_ms;
            armed_in           = 1'b1;
            sent_this_press_in = 1'b0;
            need_release_in    = ~stable_level_ff;
            press_stamp_in     = stable_level_ff ? 32'd0 : req.now_ms;
            rsp.event_res      = EV_ARMED;
            rsp.event_tag      = req.request_tag;
            rsp.armed_expiry   = clamped_expiry;
         end
         OP_CANCEL: begin
            if (!armed_ff || !req.tag_given || req.request_tag == armed_tag_ff) begin
               rsp.event_tag   = armed_ff ? armed_tag_ff : 32'd0;
               rsp.event_res   = EV_CANCELLED;
               armed_in        = 1'b0;
               need_release_in = 1'b0;
               led_level_in    = 1'b0;
            end
         end
         OP_POLL: begin
            if (req.raw_button != last_raw_ff) begin
               last_raw_in     = req.raw_button;
               bounce_stamp_in = req.now_ms;
            end
            bounce_age = req.now_ms - bounce_stamp_in;
            if (bounce_age >= {16'd0, cfg.debounce_time}
                  && req.raw_button != stable_level_ff) begin
               stable_level_in = req.raw_button;
               if (!req.raw_button) begin
                  press_stamp_in     = req.now_ms;
                  sent_this_press_in = 1'b0;
               end else begin
                  press_stamp_in  = 32'd0;
                  need_release_in = 1'b0;
               end
            end
            hold_age = req.now_ms - press_stamp_in;
            if (armed_ff && !stable_level_in && !sent_this_press_in && !need_release_in
                  && hold_age >= {16'd0, cfg.hold_time}) begin
               sent_this_press_in = 1'b1;
               rsp.event_res      = EV_APPROVED;
               rsp.event_tag      = armed_tag_ff;
               rsp.held_time      = hold_age;
               armed_in           = 1'b0;
               need_release_in    = 1'b0;
               led_level_in       = 1'b0;
               approved           = 1'b1;
            end
            if (!approved && armed_ff && (req.now_ms - arm_stamp_ff) >= expiry_value_ff) begin
               rsp.event_res   = EV_EXPIRED;
               rsp.event_tag   = armed_tag_ff;
               armed_in        = 1'b0;
               need_release_in = 1'b0;
               led_level_in    = 1'b0;
            end
            // led blinks only while a request stays armed
            interval  = stable_level_in ? cfg.blink_slow : cfg.blink_fast;
            blink_age = req.now_ms - blink_stamp_ff;
            if (!armed_in) begin
               led_level_in = 1'b0;
            end else if (blink_age >= {16'd0, interval}) begin
               blink_stamp_in = req.now_ms;
               led_level_in   = ~led_level_ff;
            end
         end
         default: begin
            rsp.event_res = EV_NONE;
         end
      endcase

      rsp.led_on      = led_level_in;
      rsp.pending_now = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff        <= 1'b1;
         stable_level_ff    <= 1'b1;
         bounce_stamp_ff    <= 32'd0;
         press_stamp_ff     <= 32'd0;
         sent_this_press_ff <= 1'b0;
         need_release_ff    <= 1'b0;
         blink_stamp_ff     <= 32'd0;
         led_level_ff       <= 1'b0;
         armed_ff           <= 1'b0;
         arm_stamp_ff       <= 32'd0;
         expiry_value_ff    <= DEFAULT_EXPIRY_RESET;
         armed_tag_ff       <= 32'd0;
      end else if (fire) begin
         last_raw_ff        <= last_raw_in;
         stable_level_ff    <= stable_level_in;
         bounce_stamp_ff    <= bounce_stamp_in;
         press_stamp_ff     <= press_stamp_in;
         sent_this_press_ff <= sent_this_press_in;
         need_release_ff    <= need_release_in;
         blink_stamp_ff     <= blink_stamp_in;
         led_level_ff       <= led_level_in;
         armed_ff           <= armed_in;
         arm_stamp_ff       <= arm_stamp_in;
         expiry_value_ff    <= expiry_value_in;
         armed_tag_ff       <= armed_tag_in;
      end
   end

endmodule

// ===== verif/hold_to_approve_button_controller_top_tb.sv =====
// self-checking testbench of the hold-to-approve button controller top level
`timescale 1ns / 100ps

module hold_to_approve_button_controller_top_tb
   import htab_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT = 100;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_now_ms = '0;
   logic        req_raw_button = 1'b1;
   logic [31:0] req_request_tag = '0;
   logic        req_tag_given = 1'b0;
   logic        req_expiry_given = 1'b0;
   logic [31:0] req_expiry_request = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [31:0] rsp_event_tag;
   logic [31:0] rsp_held_time;
   logic [31:0] rsp_armed_expiry;
   logic        rsp_led_on;
   logic        rsp_pending_now;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // controller state as the checker sees it
   cfg_type     cfg;
   logic        btn_last, btn_stable, press_reported, release_pending, led_q, req_armed;
   logic [31:0] bounce_ts, press_ts, blink_ts, armed_ts, armed_limit, armed_id;

   req_type     queued_beats[$];
   rsp_type     expected_events[$];
   rsp_type     want_rsp;
   req_type     cur_beat;
   int          beats_queued = 0;
   int          beats_taken = 0;
   int          failures = 0;
   logic [31:0] gen_ms = '0;

   logic           beat_on_bus, drain_hold;
   int             gap_left, burst_left;
   stall_mode_type stall_mode;
   int             stall_left, stall_tick;
   int             idle_cycles = 0;

   hold_to_approve_button_controller_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_now_ms         (req_now_ms),
      .req_raw_button     (req_raw_button),
      .req_request_tag    (req_request_tag),
      .req_tag_given      (req_tag_given),
      .req_expiry_given   (req_expiry_given),
      .req_expiry_request (req_expiry_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_event_tag      (rsp_event_tag),
      .rsp_held_time      (rsp_held_time),
      .rsp_armed_expiry   (rsp_armed_expiry),
      .rsp_led_on         (rsp_led_on),
      .rsp_pending_now    (rsp_pending_now),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void reset_model();
      cfg.debounce_time  = DEBOUNCE_TIME_RESET;
      cfg.hold_time      = HOLD_TIME_RESET;
      cfg.default_expiry = DEFAULT_EXPIRY_RESET;
      cfg.expiry_margin  = EXPIRY_MARGIN_RESET;
      cfg.blink_fast     = BLINK_FAST_RESET;
      cfg.blink_slow     = BLINK_SLOW_RESET;
      btn_last = 1'b1;
      btn_stable = 1'b1;
      bounce_ts = '0;
      press_ts = '0;
      press_reported = 1'b0;
      release_pending = 1'b0;
      blink_ts = '0;
      led_q = 1'b0;
      req_armed = 1'b0;
      armed_ts = '0;
      armed_limit = DEFAULT_EXPIRY_RESET;
      armed_id = '0;
   endfunction

   function automatic void clear_pending();
      req_armed = 1'b0;
      release_pending = 1'b0;
      led_q = 1'b0;
   endfunction

   function automatic rsp_type predict_controller(req_type b);
      rsp_type     r;
      logic [31:0] floor_ms, lim, held, since;
      logic        approved;
      r = '0;
      approved = 1'b0;
      case (b.opcode)
         OP_ARM: begin
            floor_ms = {16'd0, cfg.hold_time} + {16'd0, cfg.expiry_margin};
            lim = b.expiry_given ? b.expiry_request : cfg.default_expiry;
            if (lim < floor_ms) lim = floor_ms;
            armed_limit = lim;
            armed_id = b.request_tag;
            armed_ts = b.now_ms;
            req_armed = 1'b1;
            press_reported = 1'b0;
            // a press already in progress cannot approve the new request
            release_pending = ~btn_stable;
            press_ts = btn_stable ? 32'd0 : b.now_ms;
            r.event_res = EV_ARMED;
            r.event_tag = b.request_tag;
            r.armed_expiry = lim;
         end
         OP_CANCEL: begin
            if (!req_armed || !b.tag_given || b.request_tag == armed_id) begin
               r.event_tag = req_armed ? armed_id : 32'd0;
               clear_pending();
               r.event_res = EV_CANCELLED;
            end
         end
         OP_POLL: begin
            if (b.raw_button != btn_last) begin
               btn_last = b.raw_button;
               bounce_ts = b.now_ms;
            end
            since = b.now_ms - bounce_ts;
            if (since >= {16'd0, cfg.debounce_time} && b.raw_button != btn_stable) begin
               btn_stable = b.raw_button;
               if (!b.raw_button) begin
                  press_ts = b.now_ms;
                  press_reported = 1'b0;
               end else begin
                  press_ts = '0;
                  release_pending = 1'b0;
               end
            end
            if (req_armed && !btn_stable && !press_reported && !release_pending) begin
               held = b.now_ms - press_ts;
               if (held >= {16'd0, cfg.hold_time}) begin
                  press_reported = 1'b1;
                  r.event_res = EV_APPROVED;
                  r.event_tag = armed_id;
                  r.held_time = held;
                  clear_pending();
                  approved = 1'b1;
               end
            end
            // only one event per poll
            since = b.now_ms - armed_ts;
            if (!approved && req_armed && since >= armed_limit) begin
               r.event_res = EV_EXPIRED;
               r.event_tag = armed_id;
               clear_pending();
            end
            if (!req_armed) begin
               led_q = 1'b0;
            end else begin
               lim = btn_stable ? {16'd0, cfg.blink_slow} : {16'd0, cfg.blink_fast};
               since = b.now_ms - blink_ts;
               if (since >= lim) begin
                  blink_ts = b.now_ms;
                  led_q = ~led_q;
               end
            end
         end
         default: ;
      endcase
      r.led_on = led_q;
      r.pending_now = req_armed;
      return r;
   endfunction

   task automatic report_failure(string msg);
      if (failures < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
      failures++;
   endtask

   // request driver: bursts with gaps, now and then holds off until all responses are back
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         beat_on_bus = 1'b0;
         drain_hold = 1'b0;
         gap_left = 0;
         burst_left = 0;
         reset_model();
      end else begin
         if (beat_on_bus && !req_stall) begin
            expected_events.push_back(predict_controller(cur_beat));
            beats_taken++;
            beat_on_bus = 1'b0;
         end
         if (drain_hold && expected_events.size() == 0) drain_hold = 1'b0;
         if (!beat_on_bus) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (drain_hold || queued_beats.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               cur_beat = queued_beats.pop_front();
               req_opcode <= cur_beat.opcode;
               req_now_ms <= cur_beat.now_ms;
               req_raw_button <= cur_beat.raw_button;
               req_request_tag <= cur_beat.request_tag;
               req_tag_given <= cur_beat.tag_given;
               req_expiry_given <= cur_beat.expiry_given;
               req_expiry_request <= cur_beat.expiry_request;
               req_valid <= 1'b1;
               beat_on_bus = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15)
                                                         : $urandom_range(0, 2);
                  drain_hold = ($urandom_range(0, 19) == 0);
               end
            end
         end
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = STALL_NONE;
         stall_left = 0;
         stall_tick = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 80);
         end
         stall_left--;
         stall_tick++;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_tick % 5 < 2);
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            report_failure("response beat with no request outstanding");
         end else begin
            want_rsp = expected_events.pop_front();
            if (rsp_event_res !== want_rsp.event_res)
               report_failure($sformatf("event_res got %0d want %0d",
                                        rsp_event_res, want_rsp.event_res));
            if (rsp_event_tag !== want_rsp.event_tag)
               report_failure($sformatf("event_tag got %h want %h",
                                        rsp_event_tag, want_rsp.event_tag));
            if (rsp_held_time !== want_rsp.held_time)
               report_failure($sformatf("held_time got %0d want %0d",
                                        rsp_held_time, want_rsp.held_time));
            if (rsp_armed_expiry !== want_rsp.armed_expiry)
               report_failure($sformatf("armed_expiry got %0d want %0d",
                                        rsp_armed_expiry, want_rsp.armed_expiry));
            if (rsp_led_on !== want_rsp.led_on)
               report_failure($sformatf("led_on got %b want %b",
                                        rsp_led_on, want_rsp.led_on));
            if (rsp_pending_now !== want_rsp.pending_now)
               report_failure($sformatf("pending_now got %b want %b",
                                        rsp_pending_now, want_rsp.pending_now));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR at %0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         REG_DEBOUNCE_TIME:  cfg.debounce_time = value[15:0];
         REG_HOLD_TIME:      cfg.hold_time = value[15:0];
         REG_DEFAULT_EXPIRY: cfg.default_expiry = value;
         REG_EXPIRY_MARGIN:  cfg.expiry_margin = value[15:0];
         REG_BLINK_FAST:     cfg.blink_fast = value[15:0];
         REG_BLINK_SLOW:     cfg.blink_slow = value[15:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(logic [15:0] deb, logic [15:0] hold, logic [31:0] dexp,
                               logic [15:0] margin, logic [15:0] fast, logic [15:0] slow);
      write_reg(REG_DEBOUNCE_TIME, {16'd0, deb});
      write_reg(REG_HOLD_TIME, {16'd0, hold});
      write_reg(REG_DEFAULT_EXPIRY, dexp);
      write_reg(REG_EXPIRY_MARGIN, {16'd0, margin});
      write_reg(REG_BLINK_FAST, {16'd0, fast});
      write_reg(REG_BLINK_SLOW, {16'd0, slow});
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic wait_idle();
      while (beats_taken != beats_queued || expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_beat(logic [1:0] op, logic [31:0] now, logic raw, logic [31:0] tag,
                            logic tg, logic eg, logic [31:0] er);
      req_type b;
      b.opcode = op;
      b.now_ms = now;
      b.raw_button = raw;
      b.request_tag = tag;
      b.tag_given = tg;
      b.expiry_given = eg;
      b.expiry_request = er;
      queued_beats.push_back(b);
      beats_queued++;
      gen_ms = now;
   endtask

   task automatic poll_after(logic [31:0] dt, logic raw);
      push_beat(OP_POLL, gen_ms + dt, raw, $urandom, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom);
   endtask

   task automatic arm_after(logic [31:0] dt, logic [31:0] tag, logic eg, logic [31:0] er);
      push_beat(OP_ARM, gen_ms + dt, 1'($urandom_range(0, 1)), tag,
                1'($urandom_range(0, 1)), eg, er);
   endtask

   task automatic cancel_after(logic [31:0] dt, logic [31:0] tag, logic tg);
      push_beat(OP_CANCEL, gen_ms + dt, 1'($urandom_range(0, 1)), tag, tg,
                1'($urandom_range(0, 1)), $urandom);
   endtask

   // keep the button at one level until span ms have passed
   task automatic hold_level(logic raw, logic [31:0] span, logic [31:0] unit);
      logic [31:0] covered, d;
      covered = '0;
      while (covered < span) begin
         d = $urandom_range(1, unit);
         poll_after(d, raw);
         covered += d;
      end
   endtask

   // contact chatter shorter than the debounce window, ending on settle
   task automatic bounce_level(logic settle);
      int n;
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         poll_after($urandom_range(0, cfg.debounce_time / 2), (i % 2 == 0) ? ~settle : settle);
      poll_after($urandom_range(0, cfg.debounce_time / 2), settle);
   endtask

   task automatic run_scenario();
      int          kind, n;
      logic [31:0] tag, unit, hold32, deb32, floor_ms, er, lim, arm_ms;
      logic        eg;
      kind = $urandom_range(0, 9);
      tag = $urandom;
      hold32 = {16'd0, cfg.hold_time};
      deb32 = {16'd0, cfg.debounce_time};
      unit = (hold32 + deb32) / 4 + 1;
      floor_ms = hold32 + {16'd0, cfg.expiry_margin};
      eg = 1'($urandom_range(0, 1));
      er = ($urandom_range(0, 3) == 0) ? $urandom
           : floor_ms + $urandom_range(0, 8 * unit) - $urandom_range(0, unit);
      lim = eg ? er : cfg.default_expiry;
      if (lim < floor_ms) lim = floor_ms;
      case (kind)
         0, 1, 2: begin
            // arm, press through the chatter and hold, sometimes too briefly
            arm_after($urandom_range(0, unit), tag, eg, er);
            hold_level(1'b1, $urandom_range(0, 2 * unit), unit);
            bounce_level(1'b0);
            hold_level(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, hold32)
                                                         : hold32 + deb32 + unit, unit);
            bounce_level(1'b1);
            hold_level(1'b1, deb32 + unit, unit);
         end
         3: begin
            // armed during a press: needs a release and a fresh press
            bounce_level(1'b0);
            hold_level(1'b0, deb32 + unit, unit);
            arm_after($urandom_range(0, unit), tag, eg, er);
            hold_level(1'b0, hold32 + unit, unit);
            bounce_level(1'b1);
            hold_level(1'b1, deb32 + unit, unit);
            bounce_level(1'b0);
            hold_level(1'b0, hold32 + deb32 + unit, unit);
            hold_level(1'b1, deb32 + unit, unit);
         end
         4: begin
            // left alone across the expiry boundary
            arm_after($urandom_range(0, unit), tag, eg, er);
            arm_ms = gen_ms;
            hold_level(1'b1, unit, unit);
            poll_after(arm_ms + lim - 32'd1 - gen_ms, 1'b1);
            poll_after(32'd1, 1'b1);
            poll_after($urandom_range(0, unit), 1'($urandom_range(0, 1)));
         end
         5: begin
            arm_after($urandom_range(0, unit), tag, eg, er);
            poll_after($urandom_range(0, unit), 1'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
               0: cancel_after($urandom_range(0, unit), tag, 1'b1);
               1: begin
                  cancel_after($urandom_range(0, unit), tag ^ ($urandom | 32'd1), 1'b1);
                  poll_after($urandom_range(0, unit), 1'($urandom_range(0, 1)));
                  cancel_after($urandom_range(0, unit), tag, 1'b1);
               end
               default: cancel_after($urandom_range(0, unit), $urandom, 1'b0);
            endcase
            if ($urandom_range(0, 1)) cancel_after($urandom_range(0, unit), $urandom,
                                                  1'($urandom_range(0, 1)));
         end
         6: begin
            // second arm replaces the first
            arm_after($urandom_range(0, unit), $urandom, 1'($urandom_range(0, 1)), er);
            hold_level(1'b1, $urandom_range(0, unit), unit);
            arm_after($urandom_range(0, unit), tag, eg, er);
            bounce_level(1'b0);
            hold_level(1'b0, hold32 + deb32 + unit, unit);
            hold_level(1'b1, deb32 + unit, unit);
         end
         7, 8: begin
            n = $urandom_range(3, 8);
            repeat (n)
               push_beat(2'($urandom_range(OP_POLL, OP_UNUSED)),
                         $urandom_range(0, 1) ? $urandom : gen_ms + $urandom_range(0, 2 * unit),
                         1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), $urandom);
         end
         default: begin
            // long stretches at each level to watch the led toggle
            arm_after($urandom_range(0, unit), tag, 1'b1, $urandom);
            hold_level(1'b1, 4 * {16'd0, cfg.blink_slow}, {16'd0, cfg.blink_slow});
            bounce_level(1'b0);
            hold_level(1'b0, 4 * {16'd0, cfg.blink_fast}, {16'd0, cfg.blink_fast});
            hold_level(1'b1, deb32 + unit, unit);
         end
      endcase
   endtask

   task automatic fill_phase(int count);
      int goal;
      goal = beats_queued + count;
      while (beats_queued < goal) run_scenario();
      wait_idle();
   endtask

   task automatic directed_beats();
      push_beat(OP_POLL, 32'd0, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
      // cancel with nothing armed
      push_beat(OP_CANCEL, 32'd10, 1'b1, 32'h1234_5678, 1'b1, 1'b0, 32'd0);
      push_beat(OP_ARM, 32'd100, 1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'd0);
      // rearm while armed, expiry clamped up to the minimum
      push_beat(OP_ARM, 32'd110, 1'b1, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'd0);
      push_beat(OP_ARM, 32'd120, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
      // wrong tag is ignored, no tag cancels anyway
      push_beat(OP_CANCEL, 32'd130, 1'b1, 32'd0, 1'b1, 1'b0, 32'd0);
      push_beat(OP_CANCEL, 32'd140, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_ARM, 32'd150, 1'b1, 32'd1, 1'b0, 1'b1, 32'd1499);
      // press, debounce edge, hold one short then exactly enough
      push_beat(OP_POLL, 32'd200, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd234, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd235, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd1234, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd1235, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd1300, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      // armed while still pressed
      push_beat(OP_ARM, 32'd1400, 1'b0, 32'd2, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd2500, 1'b0, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd2600, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd2635, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd31399, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'd31400, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      // expiry across the timestamp wrap
      push_beat(OP_ARM, 32'hFFFF_FF00, 1'b1, 32'd3, 1'b0, 1'b1, 32'd1500);
      push_beat(OP_POLL, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_POLL, 32'h0000_04DC, 1'b1, 32'd0, 1'b0, 1'b0, 32'd0);
      push_beat(OP_ARM, 32'h0000_0500, 1'b1, 32'd4, 1'b0, 1'b0, 32'd0);
      push_beat(OP_CANCEL, 32'h0000_0510, 1'b1, 32'd4, 1'b1, 1'b0, 32'd0);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      directed_beats();
      wait_idle();

      program_regs(16'd5, 16'd40, 32'd400, 16'd10, 16'd3, 16'd11);
      fill_phase(150);
      program_regs(16'd0, 16'd1, 32'd0, 16'd0, 16'd1, 16'd1);
      fill_phase(120);
      program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      fill_phase(80);
      for (int p = 0; p < 4; p++) begin
         if (p == 1) gen_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
         program_regs(16'($urandom_range(0, 60)), 16'($urandom_range(1, 300)),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000),
                      16'($urandom_range(0, 200)), 16'($urandom_range(1, 50)),
                      16'($urandom_range(1, 150)));
         fill_phase(120);
      end
      program_regs(DEBOUNCE_TIME_RESET, HOLD_TIME_RESET, DEFAULT_EXPIRY_RESET,
                   EXPIRY_MARGIN_RESET, BLINK_FAST_RESET, BLINK_SLOW_RESET);
      fill_phase(100);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
